FILE: hdl/ape_pkg.sv
// shared types and constants for the audio playback effects block
// no dependencies; imported by every module of the block
`default_nettype none

package ape_pkg;

	localparam int WORD_W = 16;
	localparam int ACT_W  = 2;
	localparam int MODE_W = 3;

	localparam int DELAY_LEN_DEF    = 1024;
	localparam int SECTOR_WORDS_DEF = 256;

	// action codes
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DRAIN  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_START  = 2'd2;

	// play modes, codes above MODE_DELAY play as normal
	localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DOUBLE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HALF   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REV    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELAY  = 3'd4;

	// where a result word comes from
	typedef enum logic [1:0] {
		SRC_WORD,
		SRC_RING,
		SRC_STACK
	} src_t;

	typedef struct packed {
		src_t              src;
		logic [WORD_W-1:0] word;
		logic              has;
		logic              twice;
	} res_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/ape_ring.sv
// delay ring memory, read-before-write on one port, with a zeroing sweep
// depends on ape_pkg
`default_nettype none

module ape_ring #(
	parameter int DELAY_LEN = ape_pkg::DELAY_LEN_DEF,
	localparam int PW = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             clear,
	input  ape_pkg::mem_ctl_t               ctl,
	input  wire  [PW-1:0]                   addr,
	input  wire  [ape_pkg::WORD_W-1:0]      wdata,
	output logic [ape_pkg::WORD_W-1:0]      rdata,
	output logic                            busy
);
	import ape_pkg::*;

	localparam logic [PW-1:0] LAST_ADDR = PW'(DELAY_LEN - 1);

	logic [WORD_W-1:0] ring_q [DELAY_LEN];
	logic [WORD_W-1:0] rdata_q;
	logic [PW-1:0]     sweep_q;
	logic              busy_q;

	// sweep runs after reset and after each start word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end else if (clear) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end else if (busy_q) begin
			if (sweep_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end else begin
				sweep_q <= sweep_q + PW'(1);
			end
		end
	end

	// read returns the old entry when the same address is written
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_q <= ring_q[addr];
		end
		if (busy_q) begin
			ring_q[sweep_q] <= '0;
		end else if (ctl.wr) begin
			ring_q[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

FILE: hdl/ape_stack.sv
// reverse-mode stack memory, one write and one registered read port
// depends on ape_pkg
`default_nettype none

module ape_stack #(
	parameter int SECTOR_WORDS = ape_pkg::SECTOR_WORDS_DEF,
	localparam int IW = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1
) (
	input  wire                             clk,
	input  ape_pkg::mem_ctl_t               ctl,
	input  wire  [IW-1:0]                   waddr,
	input  wire  [ape_pkg::WORD_W-1:0]      wdata,
	input  wire  [IW-1:0]                   raddr,
	output logic [ape_pkg::WORD_W-1:0]      rdata
);
	import ape_pkg::*;

	logic [WORD_W-1:0] stack_q [SECTOR_WORDS];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_q <= stack_q[raddr];
		end
		if (ctl.wr) begin
			stack_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/ape_out.sv
// result stage: picks the memory data and repeats half-speed words
// into the output register; depends on ape_pkg
`default_nettype none

module ape_out (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             load,
	input  ape_pkg::res_t                   res,
	input  wire  [ape_pkg::WORD_W-1:0]      ring_rdata,
	input  wire  [ape_pkg::WORD_W-1:0]      stack_rdata,
	output logic                            free,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [ape_pkg::WORD_W-1:0]      out_sample,
	output logic                            has_sample,
	output logic                            last
);
	import ape_pkg::*;

	res_t              res_s1;
	logic              valid_s1;
	logic              second_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_sample_q;
	logic              has_q;
	logic              last_q;

	logic              take;
	logic              fire;
	logic              fin;
	logic [WORD_W-1:0] value;

	always_comb begin
		case (res_s1.src)
			SRC_RING:  value = ring_rdata;
			SRC_STACK: value = stack_rdata;
			default:   value = res_s1.word;
		endcase
	end

	assign take = !out_valid_q || out_ready;
	assign fire = valid_s1 && take;
	assign fin  = !res_s1.twice || second_s1;
	assign free = !valid_s1 || (take && fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			second_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1  <= 1'b1;
				second_s1 <= 1'b0;
			end else if (fire && fin) begin
				valid_s1 <= 1'b0;
			end else if (fire) begin
				second_s1 <= 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res;
		end
		if (fire) begin
			out_sample_q <= value;
			has_q        <= res_s1.has;
			last_q       <= fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign has_sample = has_q;
	assign last       = last_q;

endmodule

`default_nettype wire

FILE: hdl/audio_playback_effects.sv
// audio playback effects top level; depends on ape_pkg, ape_ring, ape_stack, ape_out
// a result passes the result stage register, then the output register, after acceptance
// throughput: one word per cycle unless the output stalls or the ring sweep runs;
// a half-speed word gives two results. Reset and every start word run a zeroing sweep
// of the delay ring, during which no word is accepted (mode writes are still taken)
`default_nettype none

module audio_playback_effects #(
	parameter int DELAY_LEN    = ape_pkg::DELAY_LEN_DEF,
	parameter int SECTOR_WORDS = ape_pkg::SECTOR_WORDS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [ape_pkg::MODE_W-1:0]      cfg_wdata,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [ape_pkg::ACT_W-1:0]       action,
	input  wire  [ape_pkg::WORD_W-1:0]      sample,
	input  wire                             sector_end,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [ape_pkg::WORD_W-1:0]      out_sample,
	output logic                            has_sample,
	output logic                            last
);
	import ape_pkg::*;

	localparam int PW = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
	localparam int TW = $clog2(2 * DELAY_LEN + 1);
	localparam int CW = $clog2(SECTOR_WORDS + 1);
	localparam int IW = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;

	localparam logic [PW-1:0] PTR_LAST = PW'(DELAY_LEN - 1);
	localparam logic [TW-1:0] TAIL_MAX = TW'(2 * DELAY_LEN);
	localparam logic [CW-1:0] REV_MAX  = CW'(SECTOR_WORDS);

	logic [MODE_W-1:0] play_mode_q;
	logic [1:0]        phase_q, phase_d;
	logic              right_q, right_d;
	logic [PW-1:0]     dptr_q, dptr_d, dptr_next;
	logic [TW-1:0]     tail_q, tail_d;
	logic [CW-1:0]     rcount_q, rcount_d, rtop;

	logic              accept;
	logic              ring_busy;
	logic              ring_clear;
	logic              out_free;
	logic              res_load;
	res_t              res;
	mem_ctl_t          ring_ctl;
	mem_ctl_t          stack_ctl;
	logic [WORD_W-1:0] ring_rdata;
	logic [WORD_W-1:0] stack_rdata;

	assign in_ready  = !ring_busy && out_free;
	assign accept    = in_valid && in_ready;
	assign dptr_next = (dptr_q == PTR_LAST) ? '0 : dptr_q + PW'(1);
	assign rtop      = rcount_q - CW'(1);

	always_comb begin
		phase_d    = phase_q;
		right_d    = right_q;
		dptr_d     = dptr_q;
		tail_d     = tail_q;
		rcount_d   = rcount_q;
		res.src    = SRC_WORD;
		res.word   = sample;
		res.has    = 1'b1;
		res.twice  = 1'b0;
		res_load   = 1'b0;
		ring_ctl   = '0;
		stack_ctl  = '0;
		ring_clear = 1'b0;
		if (accept) begin
			unique case (action)
				ACT_SAMPLE: begin
					unique case (play_mode_q)
						MODE_DOUBLE: begin
							res_load = (phase_q < 2'd2);
							phase_d  = sector_end ? 2'd0 : phase_q + 2'd1;
						end
						MODE_HALF: begin
							res_load  = 1'b1;
							res.twice = 1'b1;
						end
						MODE_REV: begin
							// word beyond a full sector is dropped
							if (rcount_q < REV_MAX) begin
								stack_ctl.wr = 1'b1;
								rcount_d     = rcount_q + CW'(1);
							end
						end
						MODE_DELAY: begin
							res_load = 1'b1;
							if (right_q) begin
								ring_ctl.rd = 1'b1;
								ring_ctl.wr = 1'b1;
								res.src     = SRC_RING;
								dptr_d      = dptr_next;
							end
							right_d = !right_q;
							tail_d  = '0;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
				ACT_DRAIN: begin
					res_load = 1'b1;
					if (play_mode_q == MODE_REV && rcount_q != '0) begin
						stack_ctl.rd = 1'b1;
						res.src      = SRC_STACK;
						rcount_d     = rtop;
					end else if (play_mode_q == MODE_DELAY && tail_q < TAIL_MAX) begin
						res.word = '0;
						if (right_q) begin
							ring_ctl.rd = 1'b1;
							res.src     = SRC_RING;
							dptr_d      = dptr_next;
						end
						right_d = !right_q;
						tail_d  = tail_q + TW'(1);
					end else begin
						// nothing pending
						res.word = '0;
						res.has  = 1'b0;
					end
				end
				ACT_START: begin
					ring_clear = 1'b1;
					phase_d    = '0;
					right_d    = 1'b0;
					dptr_d     = '0;
					tail_d     = '0;
					rcount_d   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q <= MODE_NORMAL;
			phase_q     <= '0;
			right_q     <= 1'b0;
			dptr_q      <= '0;
			tail_q      <= '0;
			rcount_q    <= '0;
		end else begin
			if (cfg_we) begin
				play_mode_q <= cfg_wdata;
			end
			phase_q  <= phase_d;
			right_q  <= right_d;
			dptr_q   <= dptr_d;
			tail_q   <= tail_d;
			rcount_q <= rcount_d;
		end
	end

	ape_ring #(
		.DELAY_LEN (DELAY_LEN)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (ring_clear),
		.ctl    (ring_ctl),
		.addr   (dptr_q),
		.wdata  (sample),
		.rdata  (ring_rdata),
		.busy   (ring_busy)
	);

	ape_stack #(
		.SECTOR_WORDS (SECTOR_WORDS)
	) u_stack (
		.clk   (clk),
		.ctl   (stack_ctl),
		.waddr (rcount_q[IW-1:0]),
		.wdata (sample),
		.raddr (rtop[IW-1:0]),
		.rdata (stack_rdata)
	);

	ape_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (res_load),
		.res         (res),
		.ring_rdata  (ring_rdata),
		.stack_rdata (stack_rdata),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample),
		.has_sample  (has_sample),
		.last        (last)
	);

	a_start_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_START) |=> (ring_busy && !in_ready))
		else $error("start word did not launch the ring sweep");

	a_rev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= REV_MAX)
		else $error("reverse count beyond one sector");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q <= TAIL_MAX) && (dptr_q <= PTR_LAST))
		else $error("delay tail or pointer out of range");

	a_ring_idle_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ring_busy |-> (!ring_ctl.rd && !ring_ctl.wr && !res_load))
		else $error("ring accessed during sweep");

endmodule

`default_nettype wire
